// ===== hdl/assert_macros.svh =====
// Assertion helpers
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`define ASSERT_CLK(lbl, prop, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) prop) else $error(msg);
`endif

// ===== hdl/cldt_pkg.sv =====
package cldt_pkg;
    localparam int CAPACITY = 64;
    localparam int AW = $clog2(CAPACITY);
    localparam int CW = AW + 1;

    localparam logic [2:0] CMD_APPEND     = 3'd0;
    localparam logic [2:0] CMD_READ_LIST  = 3'd1;
    localparam logic [2:0] CMD_SEARCH     = 3'd2;
    localparam logic [2:0] CMD_REMOVE     = 3'd3;
    localparam logic [2:0] CMD_MOVE_FRONT = 3'd4;
    localparam logic [2:0] CMD_MOVE_BACK  = 3'd5;
    localparam logic [2:0] CMD_READ_DEQUE = 3'd6;

    localparam logic [2:0] ST_OK         = 3'd0;
    localparam logic [2:0] ST_NOT_FOUND  = 3'd1;
    localparam logic [2:0] ST_LIST_FULL  = 3'd2;
    localparam logic [2:0] ST_DEQUE_FULL = 3'd3;
    localparam logic [2:0] ST_EMPTY      = 3'd4;

    typedef struct packed {
        logic [2:0]         cmd;
        logic signed [31:0] value;
    } in_t;

    typedef struct packed {
        logic signed [31:0] item;
        logic [2:0]         status;
        logic               last;
    } out_t;
endpackage

// ===== hdl/cldt_ram.sv =====
module cldt_ram
    import cldt_pkg::*;
(
    input  logic          aclk,
    input  logic          we,
    input  logic [AW-1:0] waddr,
    input  logic [31:0]   wdata,
    input  logic [AW-1:0] raddr,
    output logic [31:0]   rdata
);
    logic [31:0] mem [CAPACITY];

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end
endmodule

// ===== hdl/circular_list_with_deque_transfer.sv =====
// Sequencing: append and every early status result go from idle straight to the result register.
//   Search passes S_RD then S_USE for each entry compared. List and deque readouts add S_OUT per entry.
//   Remove then closes the gap in S_SHIFT, reading ahead and writing back each entry after the match.
//   A move copies each entry through S_RD and S_USE, then runs the deque readout.
// Throughput: one command at a time; not ready until the final result is taken.
// Reset: aresetn synchronous active low clears list count, deque head and count;
//   stores are not cleared.
module circular_list_with_deque_transfer
    import cldt_pkg::*;
(
    input  logic aclk,
    input  logic aresetn,
    input  logic s_valid,
    output logic s_ready,
    input  in_t  s_data,
    output logic m_valid,
    input  logic m_ready,
    output out_t m_data
);
`include "assert_macros.svh"

    // sequencer states
    localparam logic [2:0] S_IDLE  = 3'd0;
    localparam logic [2:0] S_RD    = 3'd1;  // issue list/deque read
    localparam logic [2:0] S_USE   = 3'd2;  // read data valid: compare/copy/emit
    localparam logic [2:0] S_OUT   = 3'd3;  // wait for result transfer
    localparam logic [2:0] S_SHIFT = 3'd4;  // remove: close the gap

    logic [2:0]  state_reg;
    logic [2:0]  cmd_reg;
    logic [31:0] val_reg;
    logic [CW-1:0] lcnt_reg, dcnt_reg, idx_reg;
    logic [AW-1:0] dhead_reg;
    logic        deq_walk_reg;   // walking deque for readout
    logic        mv_reg;         // move copy in progress
    logic        done_after_reg; // after result taken, go idle

    // list memory
    logic          l_we;
    logic [AW-1:0] l_waddr, l_raddr;
    logic [31:0]   l_wdata, l_rdata;
    // deque memory
    logic          d_we;
    logic [AW-1:0] d_waddr, d_raddr;
    logic [31:0]   d_rdata;

    cldt_ram u_list (.aclk, .we(l_we), .waddr(l_waddr), .wdata(l_wdata),
                     .raddr(l_raddr), .rdata(l_rdata));
    cldt_ram u_deque (.aclk, .we(d_we), .waddr(d_waddr), .wdata(l_rdata),
                      .raddr(d_raddr), .rdata(d_rdata));

    // one bit wider: both stores full must not wrap to zero
    logic [CW:0] sum_w;
    assign sum_w = {1'b0, lcnt_reg} + {1'b0, dcnt_reg};
    logic [AW-1:0] dq_idx;
    assign dq_idx = dhead_reg + idx_reg[AW-1:0];

    assign s_ready = (state_reg == S_IDLE);
    assign l_raddr = (state_reg == S_SHIFT) ? AW'(idx_reg + 1'b1) : idx_reg[AW-1:0];
    assign d_raddr = dq_idx;
    // append writes straight from the input transfer
    assign l_wdata = (state_reg == S_SHIFT) ? l_rdata : s_data.value;

    // one walk step per read cycle; shared index counter drives the walk addresses
    always_comb begin
        l_we = 1'b0;
        l_waddr = lcnt_reg[AW-1:0];
        d_we = 1'b0;
        d_waddr = dhead_reg + lcnt_reg[AW-1:0] + idx_reg[AW-1:0] - lcnt_reg[AW-1:0];
        if (state_reg == S_IDLE && s_valid && s_data.cmd == CMD_APPEND
            && lcnt_reg < CW'(CAPACITY)) begin
            l_we = 1'b1;
            l_waddr = lcnt_reg[AW-1:0];
        end
        if (state_reg == S_SHIFT && idx_reg + 1'b1 < lcnt_reg) begin
            l_we = 1'b1;
            l_waddr = idx_reg[AW-1:0];
        end
        if (state_reg == S_USE && mv_reg) begin
            d_we = 1'b1;
            if (cmd_reg == CMD_MOVE_FRONT) begin
                d_waddr = dhead_reg - 1'b1;
            end else begin
                d_waddr = dhead_reg + dcnt_reg[AW-1:0];
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_IDLE;
            lcnt_reg <= '0;
            dcnt_reg <= '0;
            dhead_reg <= '0;
            m_valid <= 1'b0;
            mv_reg <= 1'b0;
            deq_walk_reg <= 1'b0;
            done_after_reg <= 1'b0;
            idx_reg <= '0;
        end else begin
            case (state_reg)
                S_IDLE: begin
                    if (s_valid) begin
                        cmd_reg <= s_data.cmd;
                        val_reg <= s_data.value;
                        idx_reg <= '0;
                        mv_reg <= 1'b0;
                        deq_walk_reg <= 1'b0;
                        m_data.item <= '0;
                        m_data.last <= 1'b1;
                        done_after_reg <= 1'b1;
                        case (s_data.cmd)
                            CMD_APPEND: begin
                                m_data.status <= (lcnt_reg < CW'(CAPACITY)) ?
                                                 ST_OK : ST_LIST_FULL;
                                if (lcnt_reg < CW'(CAPACITY)) begin
                                    lcnt_reg <= lcnt_reg + 1'b1;
                                end
                                m_valid <= 1'b1;
                                state_reg <= S_OUT;
                            end
                            CMD_READ_LIST, CMD_SEARCH, CMD_REMOVE: begin
                                if (lcnt_reg == '0) begin
                                    m_data.status <= ST_EMPTY;
                                    m_valid <= 1'b1;
                                    state_reg <= S_OUT;
                                end else begin
                                    state_reg <= S_RD;
                                end
                            end
                            CMD_MOVE_FRONT, CMD_MOVE_BACK: begin
                                if (lcnt_reg == '0 || sum_w > (CW+1)'(CAPACITY)) begin
                                    m_data.status <= (lcnt_reg == '0) ?
                                                     ST_EMPTY : ST_DEQUE_FULL;
                                    m_valid <= 1'b1;
                                    state_reg <= S_OUT;
                                end else begin
                                    mv_reg <= 1'b1;
                                    state_reg <= S_RD;
                                end
                            end
                            CMD_READ_DEQUE: begin
                                if (dcnt_reg == '0) begin
                                    m_data.status <= ST_EMPTY;
                                    m_valid <= 1'b1;
                                    state_reg <= S_OUT;
                                end else begin
                                    deq_walk_reg <= 1'b1;
                                    state_reg <= S_RD;
                                end
                            end
                            default: ;
                        endcase
                    end
                end
                S_RD: state_reg <= S_USE;
                S_USE: begin
                    if (mv_reg) begin
                        if (cmd_reg == CMD_MOVE_FRONT) begin
                            dhead_reg <= dhead_reg - 1'b1;
                        end
                        dcnt_reg <= dcnt_reg + 1'b1;
                        if (idx_reg + 1'b1 == lcnt_reg) begin
                            // copy finished: clear list and walk deque
                            mv_reg <= 1'b0;
                            lcnt_reg <= '0;
                            deq_walk_reg <= 1'b1;
                            idx_reg <= '0;
                        end else begin
                            idx_reg <= idx_reg + 1'b1;
                        end
                        state_reg <= S_RD;
                    end else if (deq_walk_reg || cmd_reg == CMD_READ_LIST) begin
                        m_data.item <= deq_walk_reg ? d_rdata : l_rdata;
                        m_data.status <= ST_OK;
                        m_data.last <= (idx_reg + 1'b1 ==
                                        (deq_walk_reg ? dcnt_reg : lcnt_reg));
                        done_after_reg <= (idx_reg + 1'b1 ==
                                           (deq_walk_reg ? dcnt_reg : lcnt_reg));
                        idx_reg <= idx_reg + 1'b1;
                        m_valid <= 1'b1;
                        state_reg <= S_OUT;
                    end else begin
                        // search / remove compare
                        if (l_rdata == val_reg) begin
                            m_data.item <= val_reg;
                            m_data.status <= ST_OK;
                            if (cmd_reg == CMD_REMOVE) begin
                                state_reg <= S_SHIFT;
                            end else begin
                                m_valid <= 1'b1;
                                state_reg <= S_OUT;
                            end
                        end else if (idx_reg + 1'b1 == lcnt_reg) begin
                            m_data.status <= ST_NOT_FOUND;
                            m_valid <= 1'b1;
                            state_reg <= S_OUT;
                        end else begin
                            idx_reg <= idx_reg + 1'b1;
                            state_reg <= S_RD;
                        end
                    end
                end
                S_SHIFT: begin
                    // read at idx+1 registered next cycle; write uses it after a wait
                    if (idx_reg + 1'b1 >= lcnt_reg) begin
                        lcnt_reg <= lcnt_reg - 1'b1;
                        m_valid <= 1'b1;
                        state_reg <= S_OUT;
                    end else if (mv_reg) begin
                        // later phase of a step: write done, advance
                        mv_reg <= 1'b0;
                        idx_reg <= idx_reg + 1'b1;
                    end else begin
                        mv_reg <= 1'b1;
                    end
                end
                S_OUT: begin
                    if (m_ready) begin
                        m_valid <= 1'b0;
                        state_reg <= done_after_reg ? S_IDLE : S_RD;
                    end
                end
                default: state_reg <= S_IDLE;
            endcase
        end
    end

    `ASSERT_CLK(a_busy, m_valid |-> !s_ready, "result pending while ready")
    `ASSERT_CLK(a_lcnt, lcnt_reg <= CW'(CAPACITY), "list count overflow")
    `ASSERT_CLK(a_dcnt, dcnt_reg <= CW'(CAPACITY), "deque count overflow")
endmodule

// ===== tb/tb_circular_list_with_deque_transfer.sv =====
module tb_circular_list_with_deque_transfer;
    import cldt_pkg::*;

    // Reference behaviour of the list/deque pair; expected results queued in order.
    class cldt_scoreboard;
        logic signed [31:0] list_q[$];
        logic signed [31:0] deque_q[$];
        out_t               pending[$];
        int                 errors;

        function void add(logic signed [31:0] item, logic [2:0] status, logic last);
            out_t r;
            r.item = item;
            r.status = status;
            r.last = last;
            pending.push_back(r);
        endfunction

        function void emit_deque();
            if (deque_q.size() == 0) begin
                add(0, ST_EMPTY, 1'b1);
            end else begin
                foreach (deque_q[i])
                    add(deque_q[i], ST_OK, i == deque_q.size() - 1);
            end
        endfunction

        // Note one accepted command and predict what it produces.
        function void note_command(in_t c);
            int found;
            found = -1;
            foreach (list_q[i])
                if (found < 0 && list_q[i] == c.value) found = i;
            case (c.cmd)
                CMD_APPEND: begin
                    if (list_q.size() >= CAPACITY) begin
                        add(0, ST_LIST_FULL, 1'b1);
                    end else begin
                        list_q.push_back(c.value);
                        add(0, ST_OK, 1'b1);
                    end
                end
                CMD_READ_LIST: begin
                    if (list_q.size() == 0) add(0, ST_EMPTY, 1'b1);
                    else foreach (list_q[i]) add(list_q[i], ST_OK, i == list_q.size() - 1);
                end
                CMD_SEARCH, CMD_REMOVE: begin
                    if (list_q.size() == 0) begin
                        add(0, ST_EMPTY, 1'b1);
                    end else if (found < 0) begin
                        add(0, ST_NOT_FOUND, 1'b1);
                    end else begin
                        if (c.cmd == CMD_REMOVE) list_q.delete(found);
                        add(c.value, ST_OK, 1'b1);
                    end
                end
                CMD_MOVE_FRONT, CMD_MOVE_BACK: begin
                    if (list_q.size() == 0) begin
                        add(0, ST_EMPTY, 1'b1);
                    end else if (deque_q.size() + list_q.size() > CAPACITY) begin
                        add(0, ST_DEQUE_FULL, 1'b1);
                    end else begin
                        foreach (list_q[i])
                            if (c.cmd == CMD_MOVE_FRONT) deque_q.push_front(list_q[i]);
                            else deque_q.push_back(list_q[i]);
                        list_q.delete();
                        emit_deque();
                    end
                end
                CMD_READ_DEQUE: emit_deque();
                default: ;
            endcase
        endfunction

        function void check_result(out_t got);
            out_t want;
            if (pending.size() == 0) begin
                $error("result with nothing expected: item %0d status %0d last %0d",
                       got.item, got.status, got.last);
                errors++;
                return;
            end
            want = pending.pop_front();
            if (got.item !== want.item) begin
                $error("item: expected %0d, got %0d", want.item, got.item);
                errors++;
            end
            if (got.status !== want.status) begin
                $error("status: expected %0d, got %0d", want.status, got.status);
                errors++;
            end
            if (got.last !== want.last) begin
                $error("last: expected %0d, got %0d", want.last, got.last);
                errors++;
            end
        endfunction
    endclass

    logic aclk;
    logic aresetn;
    logic s_valid;
    logic s_ready;
    in_t  s_data;
    logic m_valid;
    logic m_ready;
    out_t m_data;

    cldt_scoreboard board;
    longint         cycle_count;
    bit             quiet_sink;   // stretch with no back-pressure
    bit             quiet_source; // stretch with no input gaps

    circular_list_with_deque_transfer u_dut (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .s_data  (s_data),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .m_data  (m_data)
    );

    initial begin
        aclk = 1'b0;
        forever #5 aclk = ~aclk;
    end

    // Watchdog: bounds a run of ~460 commands with up to 64 results each.
    initial begin
        cycle_count = 0;
        forever begin
            @(posedge aclk);
            cycle_count++;
            if (cycle_count > 10_000_000) begin
                $display("[circular_list_with_deque_transfer] ERROR");
                $finish;
            end
        end
    end

    // Result side: random stalls, checked on every transfer.
    initial begin
        int gap;
        m_ready = 1'b0;
        @(posedge aclk);
        while (!aresetn) @(posedge aclk);
        forever begin
            gap = quiet_sink ? 0 : $urandom_range(0, 19);
            if (gap != 0) begin
                m_ready <= 1'b0;
                repeat (gap) @(posedge aclk);
            end
            m_ready <= 1'b1;
            @(posedge aclk);
            while (!m_valid) @(posedge aclk);
            board.check_result(m_data);
        end
    end

    // Offer one command, hold it until the transfer, then note it.
    // valid stays high into the next call when there is no gap.
    task automatic send_cmd(logic [2:0] cmd, logic signed [31:0] value);
        in_t c;
        int  gap;
        c.cmd = cmd;
        c.value = value;
        gap = quiet_source ? 0 : $urandom_range(0, 19);
        if (gap != 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_valid <= 1'b1;
        s_data  <= c;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        board.note_command(c);
    endtask

    // Values drawn mostly from a small pool so searches and removals hit.
    function automatic logic signed [31:0] pick_value();
        case ($urandom_range(0, 3))
            0:       return $urandom();
            1:       return $urandom_range(0, 1) ? 32'sh7fffffff : 32'sh80000000;
            default: return $urandom_range(0, 7) - 4;
        endcase
    endfunction

    function automatic logic [2:0] pick_cmd();
        int r;
        r = $urandom_range(0, 99);
        if (r < 40) return CMD_APPEND;
        if (r < 50) return CMD_SEARCH;
        if (r < 62) return CMD_REMOVE;
        if (r < 69) return CMD_READ_LIST;
        if (r < 76) return CMD_READ_DEQUE;
        if (r < 83) return CMD_MOVE_FRONT;
        if (r < 90) return CMD_MOVE_BACK;
        if (r < 93) return 3'd7; // unused code, no result
        return $urandom_range(0, 1) ? CMD_APPEND : CMD_REMOVE;
    endfunction

    initial begin
        int waited;
        board = new();
        quiet_sink = 1'b0;
        quiet_source = 1'b0;
        aresetn = 1'b0;
        s_valid = 1'b0;
        s_data  = '0;
        repeat (4) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // Directed: empty cases first, then extremes and every command.
        send_cmd(CMD_READ_LIST, 0);
        send_cmd(CMD_SEARCH, 5);
        send_cmd(CMD_REMOVE, 5);
        send_cmd(CMD_MOVE_FRONT, 0);
        send_cmd(CMD_MOVE_BACK, 0);
        send_cmd(CMD_READ_DEQUE, 0);
        send_cmd(3'd7, 32'sh7fffffff);
        send_cmd(CMD_APPEND, 32'sh80000000);
        send_cmd(CMD_APPEND, 32'sh7fffffff);
        send_cmd(CMD_APPEND, -1);
        send_cmd(CMD_APPEND, 0);
        send_cmd(CMD_READ_LIST, 0);
        send_cmd(CMD_SEARCH, 32'sh7fffffff);
        send_cmd(CMD_SEARCH, 12345);
        send_cmd(CMD_REMOVE, 32'sh80000000);
        send_cmd(CMD_REMOVE, 12345);
        send_cmd(CMD_MOVE_FRONT, 0);
        send_cmd(CMD_APPEND, 32'sh55555555);
        send_cmd(CMD_APPEND, 32'shaaaaaaaa);
        send_cmd(CMD_MOVE_BACK, 0);
        send_cmd(CMD_READ_DEQUE, 0);

        // Fill the list to capacity, overflow it, then overflow the deque.
        quiet_source = 1'b1;
        quiet_sink = 1'b1;
        repeat (CAPACITY) send_cmd(CMD_APPEND, $urandom());
        send_cmd(CMD_APPEND, 1);
        send_cmd(CMD_MOVE_BACK, 0);
        send_cmd(CMD_READ_LIST, 0);
        send_cmd(CMD_REMOVE, pick_value());
        quiet_source = 1'b0;
        quiet_sink = 1'b0;

        // Random part, with occasional bursts free of idling on either side.
        for (int n = 0; n < 370; n++) begin
            if (n % 40 == 0) begin
                quiet_source = ($urandom_range(0, 3) == 0);
                quiet_sink = ($urandom_range(0, 3) == 0);
            end
            send_cmd(pick_cmd(), pick_value());
        end
        s_valid <= 1'b0;

        waited = 0;
        while (board.pending.size() != 0 && waited < 100_000) begin
            @(posedge aclk);
            waited++;
        end
        repeat (200) @(posedge aclk);
        if (board.pending.size() != 0) begin
            $error("%0d results never arrived", board.pending.size());
            board.errors++;
        end
        if (board.errors == 0)
            $display("[circular_list_with_deque_transfer] OK");
        else
            $display("[circular_list_with_deque_transfer] ERROR");
        $finish;
    end
endmodule
